FILE: rtl/ihc_pkg.sv
// Package for the IPv4 header checker: word types, status codes and helpers.
`default_nettype none
package ihc_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;
    localparam logic [7:0] VERSION_MASK = 8'hF0;
    localparam logic [7:0] VERSION_IPV4 = 8'h40;
    localparam logic [5:0] MIN_HEADER = 6'd20;
    localparam logic [7:0] MF_BIT = 8'h20;
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_VERSION  = 3'd1,
        ST_SHORT_HEADER = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        more_fragments;
        logic [15:0] packet_id;
    } out_word_t;

    // 16-bit ones'-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ipv4_header_check_top.sv
// IPv4 header checker: a byte-stream validator giving one result word per packet.
// Takes one packet byte per clock on the input channel and gives one result word
// after the byte marked last. A byte passes through an input register and then a
// single stage that captures header fields, adds the header into a 16-bit ones'-
// complement sum and, on the last byte, runs the version, header length, total
// length and checksum checks into the result register; a new result word is loaded
// when the stage takes a last byte while that register is free or being read. Throughput
// is one byte per cycle, bounded by the one ones'-complement add per cycle in the
// checking stage; input is held only while a finished result waits and another last
// byte arrives.
`default_nettype none
module ipv4_header_check_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ihc_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ihc_pkg::out_word_t     out_data
);
    import ihc_pkg::*;

    logic     s_valid;
    logic     s_ready;
    in_word_t s_data;

    ihc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data)
    );

    ihc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/ihc_in_reg.sv
// Input register stage for incoming packet bytes.
`default_nettype none
module ihc_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ihc_pkg::in_word_t in_data,
    output logic                  s_valid,
    input  wire logic             s_ready,
    output ihc_pkg::in_word_t     s_data
);
    import ihc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready = !valid_reg || s_ready;
    assign s_valid  = valid_reg;
    assign s_data   = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: load whenever the stage is free to take a word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ihc_core.sv
// Header field capture, checksum accumulation, checks and the result register.
`default_nettype none
module ihc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ihc_pkg::in_word_t s_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ihc_pkg::out_word_t     out_data
);
    import ihc_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         first_reg, first_next;
    logic [15:0]        total_len_reg, total_len_next;
    logic [15:0]        ident_reg, ident_next;
    logic [7:0]         flags_reg, flags_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg;

    logic [7:0]         b;
    logic [5:0]         hlen_w;
    logic               in_hdr;
    logic [15:0]        sum_final;
    logic [COUNT_W-1:0] count_inc;
    status_t            status_w;
    logic               fire;
    logic               load_res;

    assign b         = s_data.data_byte;
    assign s_ready   = !s_data.last_byte || !out_valid_reg || out_ready;
    assign fire      = s_valid && s_ready;
    assign load_res  = fire && s_data.last_byte;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_comb
    begin
        first_next     = (byte_count_reg == '0) ? b : first_reg;
        hlen_w         = {first_next[3:0], 2'b00};
        in_hdr         = byte_count_reg < {{(COUNT_W-6){1'b0}}, hlen_w};
        total_len_next = total_len_reg;
        ident_next     = ident_reg;
        flags_next     = flags_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;

        if (byte_count_reg == COUNT_W'(2))
        begin
            total_len_next[15:8] = b;
        end
        if (byte_count_reg == COUNT_W'(3))
        begin
            total_len_next[7:0] = b;
        end
        if (byte_count_reg == COUNT_W'(4))
        begin
            ident_next[15:8] = b;
        end
        if (byte_count_reg == COUNT_W'(5))
        begin
            ident_next[7:0] = b;
        end
        if (byte_count_reg == COUNT_W'(6))
        begin
            flags_next = b;
        end

        if (in_hdr)
        begin
            if (!byte_count_reg[0])
            begin
                pend_next = b;
            end
            else
            begin
                sum_next = ones_add(sum_reg, {pend_reg, b});
            end
        end

        count_inc = (byte_count_reg < COUNT_MAX) ? byte_count_reg + COUNT_W'(1)
                                                 : byte_count_reg;
        byte_count_next = count_inc;

        // odd header byte left over at the end: add it as a high byte
        sum_final = sum_next;
        if (in_hdr && !byte_count_reg[0])
        begin
            sum_final = ones_add(sum_next, {b, 8'h00});
        end

        priority if ((first_next & VERSION_MASK) != VERSION_IPV4)
        begin
            status_w = ST_BAD_VERSION;
        end
        else if (hlen_w < MIN_HEADER)
        begin
            status_w = ST_SHORT_HEADER;
        end
        else if (count_inc[COUNT_W-1] || (count_inc[15:0] != total_len_next))
        begin
            status_w = ST_LEN_MISMATCH;
        end
        else if (sum_final != SUM_GOOD)
        begin
            status_w = ST_BAD_CHECKSUM;
        end
        else
        begin
            status_w = ST_OK;
        end

        out_valid_next = out_valid_reg;
        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            first_reg      <= '0;
            total_len_reg  <= '0;
            ident_reg      <= '0;
            flags_reg      <= '0;
            sum_reg        <= '0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load_res)
            begin
                // packet done: clear for the next one
                byte_count_reg <= '0;
                first_reg      <= '0;
                total_len_reg  <= '0;
                ident_reg      <= '0;
                flags_reg      <= '0;
                sum_reg        <= '0;
                pend_reg       <= '0;
            end
            else if (fire)
            begin
                byte_count_reg <= byte_count_next;
                first_reg      <= first_next;
                total_len_reg  <= total_len_next;
                ident_reg      <= ident_next;
                flags_reg      <= flags_next;
                sum_reg        <= sum_next;
                pend_reg       <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_word_reg.status         <= status_w;
            out_word_reg.more_fragments <= (flags_next & MF_BIT) != 8'h00;
            out_word_reg.packet_id      <= ident_next;
        end
    end

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (byte_count_reg == '0) && (sum_reg == '0))
        else $error("state not cleared after final byte");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_MAX)
        else $error("byte count beyond saturation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !s_data.last_byte && (byte_count_reg < COUNT_MAX))
        |=> byte_count_reg == $past(byte_count_reg) + COUNT_W'(1))
        else $error("byte count did not advance");

    a_ok_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (load_res && (status_w == ST_OK)) |-> (hlen_w >= MIN_HEADER) && !count_inc[COUNT_W-1])
        else $error("ok status with short header or overflowed count");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_word_reg))
        else $error("pending result lost");

endmodule
`default_nettype wire

FILE: tb/ihc_result_checker.sv
// Result checker for the IPv4 header checker: predicts each packet's result word and compares.
`timescale 1ns / 1ps
module ihc_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ihc_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ihc_pkg::out_word_t out_data,
    output int                 fail_count,
    output int                 expected_left
);

    logic [16:0] rx_count;
    logic [7:0]  lead_byte;
    logic [15:0] length_field;
    logic [15:0] ident;
    logic [7:0]  frag_byte;
    logic [15:0] hdr_sum;
    logic [7:0]  hi_byte;

    ihc_pkg::out_word_t pending_verdicts[$];
    ihc_pkg::out_word_t want;

    // 16-bit add with the carry folded back in
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_packet();
        rx_count     = '0;
        lead_byte    = '0;
        length_field = '0;
        ident        = '0;
        frag_byte    = '0;
        hdr_sum      = '0;
        hi_byte      = '0;
    endtask

    task automatic track_header_byte(input logic [7:0] b, input logic last);
        logic [16:0]        idx;
        logic [6:0]         hdr_len;
        logic [15:0]        sum;
        ihc_pkg::out_word_t verdict;
        idx = rx_count;
        if (idx == 17'd0)
            lead_byte = b;
        hdr_len = {1'b0, lead_byte[3:0], 2'b00};
        case (idx)
            17'd2: length_field[15:8] = b;
            17'd3: length_field[7:0]  = b;
            17'd4: ident[15:8]        = b;
            17'd5: ident[7:0]         = b;
            17'd6: frag_byte          = b;
            default: ;
        endcase
        if (idx < hdr_len)
        begin
            if (!idx[0])
                hi_byte = b;
            else
                hdr_sum = fold_add(hdr_sum, {hi_byte, b});
        end
        if (rx_count < ihc_pkg::COUNT_MAX)
            rx_count = rx_count + 17'd1;
        if (last)
        begin
            // an odd header byte left over counts as a high byte
            sum = hdr_sum;
            if (idx < hdr_len && !idx[0])
                sum = fold_add(sum, {hi_byte, 8'h00});
            verdict.more_fragments = |(frag_byte & ihc_pkg::MF_BIT);
            verdict.packet_id      = ident;
            if ((lead_byte & ihc_pkg::VERSION_MASK) != ihc_pkg::VERSION_IPV4)
                verdict.status = ihc_pkg::ST_BAD_VERSION;
            else if (hdr_len < ihc_pkg::MIN_HEADER)
                verdict.status = ihc_pkg::ST_SHORT_HEADER;
            else if (rx_count > 17'd65535 || rx_count != {1'b0, length_field})
                verdict.status = ihc_pkg::ST_LEN_MISMATCH;
            else if (sum != ihc_pkg::SUM_GOOD)
                verdict.status = ihc_pkg::ST_BAD_CHECKSUM;
            else
                verdict.status = ihc_pkg::ST_OK;
            pending_verdicts.push_back(verdict);
            clear_packet();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_packet();
            pending_verdicts.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: status %0d mf %0d id %h",
                                 out_data.status, out_data.more_fragments, out_data.packet_id);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (out_data.status !== want.status
                        || out_data.more_fragments !== want.more_fragments
                        || out_data.packet_id !== want.packet_id)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("result mismatch: expected status %0d mf %0d id %h,",
                                   want.status, want.more_fragments, want.packet_id);
                            $display(" got status %0d mf %0d id %h",
                                     out_data.status, out_data.more_fragments,
                                     out_data.packet_id);
                        end
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                track_header_byte(in_data.data_byte, in_data.last_byte);
            expected_left = pending_verdicts.size();
        end
    end

endmodule

FILE: tb/ipv4_header_check_top_test.sv
// Testbench top for the IPv4 header checker: packet stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module ipv4_header_check_top_test;

    localparam int ITEM_TARGET  = 1250;
    localparam int MIN_PACKETS  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FAULT_VERSION,
        FAULT_IHL,
        FAULT_LENGTH,
        FAULT_SUM,
        FAULT_TRUNCATE,
        FAULT_EXTEND
    } fault_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    ihc_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ihc_pkg::out_word_t out_data;

    int fail_count;
    int expected_left;
    int burst_left = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int hold_req = 0;
    int idle_cycles = 0;

    logic [7:0] pkt[$];

    ipv4_header_check_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ihc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one word, with a random gap between bursts
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
        packets_sent++;
    endtask

    // Well-formed packet: version 4, matching total length, valid header checksum
    task automatic build_ipv4_packet(input int ihl, input int payload);
        int          i;
        int          hdr;
        int          total;
        logic [16:0] s;
        logic [15:0] acc;
        hdr   = ihl * 4;
        total = hdr + payload;
        pkt.delete();
        for (i = 0; i < total; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
        pkt[0]  = ihc_pkg::VERSION_IPV4 | 8'(ihl);
        pkt[2]  = total[15:8];
        pkt[3]  = total[7:0];
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        acc = '0;
        for (i = 0; i < hdr; i += 2)
        begin
            s   = {1'b0, acc} + {1'b0, pkt[i], pkt[i + 1]};
            acc = s[15:0] + {15'd0, s[16]};
        end
        pkt[10] = ~acc[15:8];
        pkt[11] = ~acc[7:0];
    endtask

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       phase;
        int       hold_seen;
        out_ready <= 1'b0;
        mode      = RX_FREE;
        mode_left = 0;
        phase     = 0;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (phase % 4 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("ipv4_header_check_top_test NOT OK");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        fault_t     fault;
        int         ihl;
        int         idx;
        int         pick;
        logic [7:0] lead;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single bytes at both extremes, then a short header
        pkt = '{8'hFF};
        send_packet();
        pkt = '{8'h00};
        send_packet();
        pkt = '{8'h41};
        send_packet();
        // total length never received
        pkt = '{8'h45, 8'h00};
        send_packet();
        // header cut short with an odd byte left over, yet summing to all ones
        pkt = '{8'h45, 8'h00, 8'h00, 8'h07, 8'h9A, 8'hF8, 8'h20};
        send_packet();
        // header cut short on an even byte, bad sum
        pkt = '{8'h45, 8'h00, 8'h00, 8'h06, 8'hFF, 8'hFF};
        send_packet();

        while (bytes_sent < ITEM_TARGET || packets_sent < MIN_PACKETS)
        begin
            // stall the receiver twice so the result path backs up
            if (packets_sent == 10 || packets_sent == 40)
                hold_req <= hold_req + 1;
            pick = $urandom_range(0, 99);
            if (pick < 90)
            begin
                ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
                build_ipv4_packet(ihl, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                                   : $urandom_range(0, 6));
                if (pick >= 65)
                begin
                    fault = fault_t'($urandom_range(0, 5));
                    lead  = pkt[0];
                    case (fault)
                        FAULT_VERSION: pkt[0] = {4'(4 + $urandom_range(1, 15)), lead[3:0]};
                        FAULT_IHL:     pkt[0] = {lead[7:4], 4'($urandom_range(0, 4))};
                        FAULT_LENGTH:  pkt[3] = pkt[3] ^ 8'($urandom_range(1, 255));
                        FAULT_SUM:
                        begin
                            idx      = $urandom_range(10, ihl * 4 - 1);
                            pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
                        end
                        FAULT_TRUNCATE:
                            repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
                        default:
                            repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                pkt.delete();
                repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    pkt[0] = ihc_pkg::VERSION_IPV4 | (pkt[0] & 8'h0F);
            end
            send_packet();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("ipv4_header_check_top_test OK");
        else
            $display("ipv4_header_check_top_test NOT OK");
        $finish;
    end

endmodule
